// ===== src/tlxbm_pkg.sv =====
// Shared types, register indexes and a helper function for the two-LFSR byte masker.
package tlxbm_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_SEED_A       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_A        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_A     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_B       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_B        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_B     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_HDR_MASK_EN  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_BYTES = 3'd7;

  localparam logic [31:0] SEED_A_RST       = 32'd46249;
  localparam logic [4:0]  TAP_A_RST        = 5'd7;
  localparam logic [5:0]  LENGTH_A_RST     = 6'd16;
  localparam logic [31:0] SEED_B_RST       = 32'd55979;
  localparam logic [4:0]  TAP_B_RST        = 5'd31;
  localparam logic [5:0]  LENGTH_B_RST     = 6'd32;
  localparam logic        HDR_MASK_EN_RST  = 1'b1;
  localparam logic [15:0] HEADER_BYTES_RST = 16'd0;

  localparam logic [15:0] HEADER_COUNT_MAX = 16'hFFFF;

  // Tap and length of one shift register.
  typedef struct packed {
    logic [4:0] tap;
    logic [5:0] length;
  } lfsr_cfg_t;

  // Length as the hardware uses it: zero acts as one, and anything above
  // the register width acts as the full width.
  function automatic logic [6:0] eff_len(logic [5:0] length, logic [6:0] max_w);
    logic [6:0] n;
    n = {1'b0, length};
    if (n == 7'd0) begin
      n = 7'd1;
    end else if (n > max_w) begin
      n = max_w;
    end
    return n;
  endfunction

endpackage

// ===== src/tlxbm_in_if.sv =====
// Input channel: one data byte per beat with a stream restart flag.
interface tlxbm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_stream;

  modport source (output valid, output data_byte, output new_stream, input ready);
  modport sink   (input valid, input data_byte, input new_stream, output ready);
endinterface

// ===== src/tlxbm_out_if.sv =====
// Output channel: masked byte, the mask used and the pass-through flag per beat.
interface tlxbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic [7:0] key_byte;
  logic       passed_through;

  modport source (output valid, output cipher_byte, output key_byte,
                  output passed_through, input ready);
  modport sink   (input valid, input cipher_byte, input key_byte,
                  input passed_through, output ready);
endinterface

// ===== src/tlxbm_lfsr.sv =====
// One right-shifting two-tap LFSR advanced a fixed number of steps in one pass.
module tlxbm_lfsr #(
  parameter int unsigned STATE_WIDTH   = 32,
  parameter int unsigned BITS_PER_ITEM = 8
) (
  input  logic [STATE_WIDTH-1:0]              state,
  input  tlxbm_pkg::lfsr_cfg_t                cfg,
  output logic [STATE_WIDTH-1:0]              state_next,
  output logic [BITS_PER_ITEM-1:0]            new_bits
);
  import tlxbm_pkg::*;

  logic [6:0] n;

  assign n = eff_len(cfg.length, 7'(STATE_WIDTH));

  always_comb begin
    logic [STATE_WIDTH-1:0] s;
    logic [STATE_WIDTH-1:0] shifted;
    logic                   t;
    logic                   nb;
    for (int j = 0; j < STATE_WIDTH; j++) begin
      s[j] = state[j] & (j < int'(n));
    end
    new_bits = '0;
    for (int k = 0; k < BITS_PER_ITEM; k++) begin
      t = 1'b0;
      for (int j = 0; j < STATE_WIDTH; j++) begin
        if ((j == int'(cfg.tap)) && (j < int'(n))) begin
          t = s[j];
        end
      end
      nb      = s[0] ^ t;
      shifted = s >> 1;
      // The new bit replaces the top position of the configured length.
      for (int j = 0; j < STATE_WIDTH; j++) begin
        if (j == int'(n) - 1) begin
          s[j] = nb;
        end else if (j < int'(n) - 1) begin
          s[j] = shifted[j];
        end else begin
          s[j] = 1'b0;
        end
      end
      new_bits[k] = nb;
    end
    state_next = s;
  end

endmodule

// ===== src/two_lfsr_xor_byte_masker_top.sv =====
// Byte masker: two configurable LFSRs XORed, one byte per cycle unless stalled.
//
// Usage: bytes enter on data_in, one beat per byte, and the results leave on
// data_out in the same order, one beat per input beat. Each beat carries the
// masked byte, the mask byte and a flag telling whether the byte was a header
// byte passed through unchanged. Setting new_stream on a beat reloads both
// shift registers from their seeds and clears the header count before that
// byte is handled. Configuration is written through cfg_we, cfg_index and
// cfg_data while no bytes are in flight; seed writes take effect only at the
// next new_stream; a reset reloads the default seeds instead.
// Path: a byte taken on data_in goes to the input stage and then to the output
// register, from which data_out presents its result.
// Throughput: one byte per cycle while data_out is ready; both LFSRs advance
// all their steps for a byte in a single combinational pass between the input
// stage and the output register.
// Reset: configuration returns to its defaults, the shift registers load the
// default seeds and the header count clears; no result is pending.
// Stall: when data_out is not ready the output register holds its beat, the
// input stage keeps one more byte, and data_in then deasserts ready.
module two_lfsr_xor_byte_masker_top #(
  parameter int unsigned STATE_WIDTH   = 32,
  parameter int unsigned BITS_PER_ITEM = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  tlxbm_in_if.sink                             data_in,
  tlxbm_out_if.source                          data_out,
  input  logic                                 cfg_we,
  input  logic [tlxbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tlxbm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tlxbm_pkg::*;

  // Configuration registers.
  logic [31:0] seed_a;
  logic [31:0] seed_b;
  lfsr_cfg_t   cfg_a;
  lfsr_cfg_t   cfg_b;
  logic        hdr_mask_en;
  logic [15:0] header_bytes;

  // Running state.
  logic [STATE_WIDTH-1:0] shift_a;
  logic [STATE_WIDTH-1:0] shift_b;
  logic [15:0]            header_count;

  // Input stage.
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_new_stream;

  // Output register.
  logic       out_valid;
  logic [7:0] out_masked;
  logic [7:0] out_mask;
  logic       out_passed;

  logic                     advance;
  logic                     take;
  logic [STATE_WIDTH-1:0]   cur_a;
  logic [STATE_WIDTH-1:0]   cur_b;
  logic [15:0]              cur_count;
  logic                     header;
  logic [STATE_WIDTH-1:0]   step_a;
  logic [STATE_WIDTH-1:0]   step_b;
  logic [BITS_PER_ITEM-1:0] bits_a;
  logic [BITS_PER_ITEM-1:0] bits_b;
  logic [7:0]               mask;
  logic [15:0]              header_count_next;

  function automatic logic [STATE_WIDTH-1:0] trim_seed(logic [31:0] seed, logic [5:0] length);
    logic [63:0]            wide;
    logic [6:0]             n;
    logic [STATE_WIDTH-1:0] r;
    wide = {32'd0, seed};
    n    = eff_len(length, 7'(STATE_WIDTH));
    for (int j = 0; j < STATE_WIDTH; j++) begin
      r[j] = wide[j] & (j < int'(n));
    end
    return r;
  endfunction

  assign advance       = !out_valid || data_out.ready;
  assign data_in.ready = !s1_valid || advance;
  assign take          = s1_valid && advance;

  assign cur_a     = s1_new_stream ? trim_seed(seed_a, cfg_a.length) : shift_a;
  assign cur_b     = s1_new_stream ? trim_seed(seed_b, cfg_b.length) : shift_b;
  assign cur_count = s1_new_stream ? 16'd0 : header_count;
  assign header    = !hdr_mask_en && (cur_count < header_bytes);

  tlxbm_lfsr #(
    .STATE_WIDTH   (STATE_WIDTH),
    .BITS_PER_ITEM (BITS_PER_ITEM)
  ) u_lfsr_a (
    .state      (cur_a),
    .cfg        (cfg_a),
    .state_next (step_a),
    .new_bits   (bits_a)
  );

  tlxbm_lfsr #(
    .STATE_WIDTH   (STATE_WIDTH),
    .BITS_PER_ITEM (BITS_PER_ITEM)
  ) u_lfsr_b (
    .state      (cur_b),
    .cfg        (cfg_b),
    .state_next (step_b),
    .new_bits   (bits_b)
  );

  // The first step's bit lands in the most significant mask position.
  always_comb begin
    mask = 8'd0;
    if (!header) begin
      for (int k = 0; k < BITS_PER_ITEM; k++) begin
        mask[BITS_PER_ITEM-1-k] = bits_a[k] ^ bits_b[k];
      end
    end
  end

  assign header_count_next = (cur_count < HEADER_COUNT_MAX) ? cur_count + 16'd1 : cur_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_a       <= SEED_A_RST;
      cfg_a.tap    <= TAP_A_RST;
      cfg_a.length <= LENGTH_A_RST;
      seed_b       <= SEED_B_RST;
      cfg_b.tap    <= TAP_B_RST;
      cfg_b.length <= LENGTH_B_RST;
      hdr_mask_en  <= HDR_MASK_EN_RST;
      header_bytes <= HEADER_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED_A:       seed_a       <= cfg_data;
        REG_TAP_A:        cfg_a.tap    <= cfg_data[4:0];
        REG_LENGTH_A:     cfg_a.length <= cfg_data[5:0];
        REG_SEED_B:       seed_b       <= cfg_data;
        REG_TAP_B:        cfg_b.tap    <= cfg_data[4:0];
        REG_LENGTH_B:     cfg_b.length <= cfg_data[5:0];
        REG_HDR_MASK_EN:  hdr_mask_en  <= cfg_data[0];
        REG_HEADER_BYTES: header_bytes <= cfg_data[15:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_a      <= trim_seed(SEED_A_RST, LENGTH_A_RST);
      shift_b      <= trim_seed(SEED_B_RST, LENGTH_B_RST);
      header_count <= 16'd0;
    end else if (take) begin
      // Header bytes leave both registers where they are.
      shift_a      <= header ? cur_a : step_a;
      shift_b      <= header ? cur_b : step_b;
      header_count <= header_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_in.ready) begin
      s1_valid <= data_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_in.ready && data_in.valid) begin
      s1_data       <= data_in.data_byte;
      s1_new_stream <= data_in.new_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_masked <= s1_data ^ mask;
      out_mask   <= mask;
      out_passed <= header;
    end
  end

  assign data_out.valid          = out_valid;
  assign data_out.cipher_byte    = out_masked;
  assign data_out.key_byte       = out_mask;
  assign data_out.passed_through = out_passed;

endmodule
